[src/btmx_pkg.sv]
// Shared types, codes and the microcode program for the binary trie max-XOR unit.
package btmx_pkg;

  localparam int VALUE_W  = 31;
  localparam int STATUS_W = 2;
  localparam int PC_W     = 4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // datapath operations, one per microcode step
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_QWALK,
    OP_IWALK,
    OP_ALLOC_PARENT,
    OP_ALLOC_FRESH,
    OP_SET_FULL,
    OP_EMIT
  } op_t;

  // branch conditions
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_BEAT,
    COND_INSERT,
    COND_EMPTY,
    COND_MORE,
    COND_MISS,
    COND_FULL,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] jump;
    logic [PC_W-1:0] next;
  } ctrl_t;

  // step addresses
  localparam logic [PC_W-1:0] STEP_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] STEP_DISP   = 4'd1;
  localparam logic [PC_W-1:0] STEP_QCHK   = 4'd2;
  localparam logic [PC_W-1:0] STEP_QWALK  = 4'd3;
  localparam logic [PC_W-1:0] STEP_IWALK  = 4'd4;
  localparam logic [PC_W-1:0] STEP_IDUP   = 4'd5;
  localparam logic [PC_W-1:0] STEP_ICHK   = 4'd6;
  localparam logic [PC_W-1:0] STEP_IPAR   = 4'd7;
  localparam logic [PC_W-1:0] STEP_IFRESH = 4'd8;
  localparam logic [PC_W-1:0] STEP_IFULL  = 4'd9;
  localparam logic [PC_W-1:0] STEP_EMIT   = 4'd10;

  // control store: pc <= cond ? jump : next
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    unique case (pc)
      STEP_IDLE:   w = '{OP_LOAD,         COND_IN_BEAT,  STEP_DISP,   STEP_IDLE};
      STEP_DISP:   w = '{OP_NONE,         COND_INSERT,   STEP_IWALK,  STEP_QCHK};
      STEP_QCHK:   w = '{OP_NONE,         COND_EMPTY,    STEP_EMIT,   STEP_QWALK};
      STEP_QWALK:  w = '{OP_QWALK,        COND_MORE,     STEP_QWALK,  STEP_EMIT};
      STEP_IWALK:  w = '{OP_IWALK,        COND_MORE,     STEP_IWALK,  STEP_IDUP};
      STEP_IDUP:   w = '{OP_NONE,         COND_MISS,     STEP_ICHK,   STEP_EMIT};
      STEP_ICHK:   w = '{OP_NONE,         COND_FULL,     STEP_IFULL,  STEP_IPAR};
      STEP_IPAR:   w = '{OP_ALLOC_PARENT, COND_ALWAYS,   STEP_IFRESH, STEP_IFRESH};
      STEP_IFRESH: w = '{OP_ALLOC_FRESH,  COND_MORE,     STEP_IFRESH, STEP_EMIT};
      STEP_IFULL:  w = '{OP_SET_FULL,     COND_ALWAYS,   STEP_EMIT,   STEP_EMIT};
      STEP_EMIT:   w = '{OP_EMIT,         COND_OUT_FREE, STEP_IDLE,   STEP_EMIT};
      default:     w = '{OP_NONE,         COND_ALWAYS,   STEP_IDLE,   STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

[src/btmx_if.sv]
// Valid/ready channel interfaces for the item and result beats.
interface btmx_item_if import btmx_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface btmx_result_if import btmx_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  best_xor;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output best_xor, output status, input ready);
  modport sink   (input valid, input best_xor, input status, output ready);
endinterface

[src/btmx_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
module btmx_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/binary_trie_max_xor_unit.sv]
// Top level: binary trie of keys with insert and maximum-XOR query, microcoded control.
//
// Each item beat carries func (0 insert, 1 query) and a key; exactly one result beat
// comes back per item, in order. Inserts walk the trie from the top key bit and, if
// the free nodes can hold the whole missing path, allocate it (else status full and
// nothing changes). Queries walk the trie taking the opposite child where it exists
// and return the largest key XOR stored value (status empty before any insert).
// One item is in work at a time. The insert walk (one node-store read per level)
// stops at the first missing child and one node-store write per newly allocated
// node covers the levels below it, so walk and allocation together cover every
// key level, with the check and link steps between them.
// A result may sit in the output register while the next item is accepted. The
// root node lives in flip-flops cleared by reset; the node store needs no clearing
// pass, since every node is written when allocated before it is ever read.
module binary_trie_max_xor_unit import btmx_pkg::*; #(
  parameter int KEY_BITS   = 31,
  parameter int NODE_COUNT = 4096
) (
  input  logic          clk,
  input  logic          rst,
  btmx_item_if.sink     item,
  btmx_result_if.source result
);

  localparam int LINK_W = $clog2(NODE_COUNT);
  localparam int CNT_W  = LINK_W + 1;
  localparam int SUM_W  = CNT_W + 1;
  localparam int BIT_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int NODE_W = 2 * LINK_W;

  // sequencer
  logic [PC_W-1:0] pc;
  ctrl_t           uw;
  logic            cond_true;

  // datapath registers
  logic [KEY_BITS-1:0] key;
  logic                func;
  logic [BIT_W-1:0]    bit_pos;
  logic [LINK_W-1:0]   cur;
  logic [LINK_W-1:0]   cur_next;
  logic [KEY_BITS-1:0] best;
  logic                miss;
  logic [STATUS_W-1:0] status_r;
  logic [NODE_W-1:0]   par_node;
  logic [NODE_W-1:0]   root_node;
  logic [CNT_W-1:0]    nodes_used;
  logic                holds_any;

  // output register
  logic                out_valid;
  logic [VALUE_W-1:0]  out_best;
  logic [STATUS_W-1:0] out_status;

  // node store ports
  logic              ram_we;
  logic [LINK_W-1:0] ram_waddr;
  logic [NODE_W-1:0] ram_wdata;
  logic [NODE_W-1:0] ram_rdata;

  // walk decode
  logic [NODE_W-1:0] node_data;
  logic [LINK_W-1:0] link0, link1;
  logic              key_bit, below_bit, last;
  logic [LINK_W-1:0] q_want, q_same, i_next;
  logic              more, full;
  logic              in_beat, out_free;
  logic [LINK_W-1:0] fresh, fresh_after;
  logic [NODE_W-1:0] parent_data, fresh_data;

  assign uw = ucode(pc);

  assign item.ready      = (pc == STEP_IDLE);
  assign in_beat         = item.valid & item.ready;
  assign out_free        = ~out_valid | result.ready;
  assign result.valid    = out_valid;
  assign result.best_xor = out_best;
  assign result.status   = out_status;

  // root comes from flops, every other node from the store's registered read,
  // which was addressed with cur_next in the previous cycle
  assign node_data = (cur == '0) ? root_node : ram_rdata;
  assign link0     = node_data[LINK_W-1:0];
  assign link1     = node_data[NODE_W-1:LINK_W];
  assign key_bit   = key[bit_pos];
  assign last      = (bit_pos == '0);
  assign below_bit = last ? 1'b0 : key[bit_pos - BIT_W'(1)];
  assign q_want    = key_bit ? link0 : link1;
  assign q_same    = key_bit ? link1 : link0;
  assign i_next    = key_bit ? link1 : link0;

  // need = bit_pos + 1 fresh nodes from the miss point down to the leaf
  assign full = ({1'b0, nodes_used} + SUM_W'(bit_pos) + SUM_W'(1)) > SUM_W'(NODE_COUNT);

  assign fresh       = nodes_used[LINK_W-1:0];
  assign fresh_after = LINK_W'(nodes_used + CNT_W'(1));
  assign parent_data = key_bit ? {fresh, par_node[LINK_W-1:0]}
                               : {par_node[NODE_W-1:LINK_W], fresh};
  always_comb begin
    if (last) begin
      fresh_data = '0;
    end else if (below_bit) begin
      fresh_data = {fresh_after, {LINK_W{1'b0}}};
    end else begin
      fresh_data = {{LINK_W{1'b0}}, fresh_after};
    end
  end

  always_comb begin
    case (uw.op)
      OP_QWALK:       more = ~last & ((q_want != '0) | (q_same != '0));
      OP_IWALK:       more = ~last & (i_next != '0);
      OP_ALLOC_FRESH: more = ~last;
      default:        more = 1'b0;
    endcase
  end

  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS:   cond_true = 1'b1;
      COND_IN_BEAT:  cond_true = in_beat;
      COND_INSERT:   cond_true = ~func;
      COND_EMPTY:    cond_true = (status_r == STATUS_EMPTY);
      COND_MORE:     cond_true = more;
      COND_MISS:     cond_true = miss;
      COND_FULL:     cond_true = full;
      COND_OUT_FREE: cond_true = out_free;
      default:       cond_true = 1'b0;
    endcase
  end

  // next node address; also the read address so data lands as cur updates
  always_comb begin
    cur_next = cur;
    case (uw.op)
      OP_LOAD: begin
        if (in_beat) begin
          cur_next = '0;
        end
      end
      OP_QWALK: begin
        if (q_want != '0) begin
          cur_next = q_want;
        end else if (q_same != '0) begin
          cur_next = q_same;
        end
      end
      OP_IWALK: begin
        if (i_next != '0) begin
          cur_next = i_next;
        end
      end
      default: cur_next = cur;
    endcase
  end

  assign ram_we    = ((uw.op == OP_ALLOC_PARENT) & (cur != '0)) | (uw.op == OP_ALLOC_FRESH);
  assign ram_waddr = (uw.op == OP_ALLOC_PARENT) ? cur : fresh;
  assign ram_wdata = (uw.op == OP_ALLOC_PARENT) ? parent_data : fresh_data;

  btmx_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur_next),
    .rdata (ram_rdata)
  );

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= cond_true ? uw.jump : uw.next;
    end
  end

  // trie bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      root_node  <= '0;
      nodes_used <= CNT_W'(1);
      holds_any  <= 1'b0;
    end else begin
      if ((uw.op == OP_ALLOC_PARENT) && (cur == '0)) begin
        root_node <= parent_data;
      end
      if (uw.op == OP_ALLOC_FRESH) begin
        nodes_used <= nodes_used + CNT_W'(1);
        holds_any  <= 1'b1;
      end
    end
  end

  // walk registers (payload, no reset)
  always_ff @(posedge clk) begin
    cur <= cur_next;
    case (uw.op)
      OP_LOAD: begin
        if (in_beat) begin
          key      <= KEY_BITS'({1'b0, item.value});
          func     <= item.func;
          bit_pos  <= BIT_W'(KEY_BITS - 1);
          best     <= '0;
          miss     <= 1'b0;
          status_r <= (item.func & ~holds_any) ? STATUS_EMPTY : STATUS_OK;
        end
      end
      OP_QWALK: begin
        if (q_want != '0) begin
          best[bit_pos] <= 1'b1;
        end
        if (more) begin
          bit_pos <= bit_pos - BIT_W'(1);
        end
      end
      OP_IWALK: begin
        par_node <= node_data;
        if (i_next == '0) begin
          miss <= 1'b1;
        end else if (!last) begin
          bit_pos <= bit_pos - BIT_W'(1);
        end
      end
      OP_ALLOC_FRESH: begin
        if (!last) begin
          bit_pos <= bit_pos - BIT_W'(1);
        end
      end
      OP_SET_FULL: status_r <= STATUS_FULL;
      default: ;
    endcase
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((uw.op == OP_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((uw.op == OP_EMIT) && out_free) begin
      out_best   <= VALUE_W'({{VALUE_W{1'b0}}, best});
      out_status <= status_r;
    end
  end

endmodule

[dv/binary_trie_max_xor_unit_tb.sv]
// Testbench for binary_trie_max_xor_unit: trie predictor, in-order scoreboard, random traffic.

// item opcode as carried in the func field of an item beat
typedef enum bit {FUNC_INSERT = 1'b0, FUNC_QUERY = 1'b1} item_func_t;

// Scoreboard: keeps its own copy of the trie, works out the result of every
// accepted item beat and checks result beats against them in order.
class trie_scoreboard;
  localparam int KEY_BITS   = 31;
  localparam int NODE_COUNT = 4096;

  typedef struct {
    logic [btmx_pkg::VALUE_W-1:0]  best_xor;
    logic [btmx_pkg::STATUS_W-1:0] status;
  } xor_result_t;

  // child links per node, 0 = no child (root is never a child)
  bit [12:0]   child[NODE_COUNT][2];
  int unsigned nodes_used;
  bit          holds_any;
  xor_result_t pending[$];
  int          errors;

  function new();
    nodes_used  = 1;
    holds_any   = 1'b0;
    child[0][0] = '0;
    child[0][1] = '0;
    errors      = 0;
  endfunction

  task report_mismatch(string msg);
    if (errors < 40) $display("tb: mismatch: %s", msg);
    errors++;
  endtask

  // all-or-nothing path allocation; refused when the free nodes fall short
  function logic [btmx_pkg::STATUS_W-1:0] insert_key(logic [KEY_BITS-1:0] key);
    int cur;
    int need;
    int fresh;
    cur  = 0;
    need = 0;
    for (int b = KEY_BITS - 1; b >= 0; b--) begin
      if (child[cur][key[b]] == 0) begin
        need = b + 1;
        break;
      end
      cur = child[cur][key[b]];
    end
    if (nodes_used + need > NODE_COUNT) return btmx_pkg::STATUS_FULL;
    cur = 0;
    for (int b = KEY_BITS - 1; b >= 0; b--) begin
      if (child[cur][key[b]] == 0) begin
        fresh = nodes_used;
        child[fresh][0] = '0;
        child[fresh][1] = '0;
        child[cur][key[b]] = fresh[12:0];
        nodes_used++;
      end
      cur = child[cur][key[b]];
    end
    holds_any = 1'b1;
    return btmx_pkg::STATUS_OK;
  endfunction

  // greedy walk: opposite child first, else same side, else stop
  function logic [KEY_BITS-1:0] best_match(logic [KEY_BITS-1:0] key);
    int                  cur;
    logic [KEY_BITS-1:0] best;
    bit                  qb;
    cur  = 0;
    best = '0;
    for (int b = KEY_BITS - 1; b >= 0; b--) begin
      qb = key[b];
      if (child[cur][qb ^ 1'b1] != 0) begin
        best[b] = 1'b1;
        cur     = child[cur][qb ^ 1'b1];
      end else if (child[cur][qb] != 0) begin
        cur = child[cur][qb];
      end else begin
        break;
      end
    end
    return best;
  endfunction

  function void note_item(logic func, logic [btmx_pkg::VALUE_W-1:0] value);
    xor_result_t r;
    r.best_xor = '0;
    r.status   = btmx_pkg::STATUS_OK;
    if (func == FUNC_INSERT) begin
      r.status = insert_key(value);
    end else if (!holds_any) begin
      r.status = btmx_pkg::STATUS_EMPTY;
    end else begin
      r.best_xor = best_match(value);
    end
    pending.push_back(r);
  endfunction

  task check_result(logic [btmx_pkg::VALUE_W-1:0] got_xor,
                    logic [btmx_pkg::STATUS_W-1:0] got_status);
    xor_result_t want;
    if (pending.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing pending: best_xor=%h status=%0d",
                                got_xor, got_status));
      return;
    end
    want = pending.pop_front();
    if (got_xor !== want.best_xor)
      report_mismatch($sformatf("best_xor got %h want %h", got_xor, want.best_xor));
    if (got_status !== want.status)
      report_mismatch($sformatf("status got %0d want %0d", got_status, want.status));
  endtask
endclass

module binary_trie_max_xor_unit_tb import btmx_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Run bounds. Slowest legal item: a full-depth insert, plus a long sink stall
  // and a long sender gap; ~870 items stay far below.
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 80;   // > longest insert work
  localparam int POOL_MAX     = 512;

  logic clk = 1'b0;
  logic rst = 1'b1;

  btmx_item_if   item ();
  btmx_result_if result ();

  binary_trie_max_xor_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result)
  );

  trie_scoreboard sb = new();

  // keys already offered for insert; seeds for keys that share long prefixes
  logic [VALUE_W-1:0] key_pool[$];

  // per-phase idling switches
  bit sender_gaps_on = 1'b0;
  bit sink_stalls_on = 1'b0;

  int unsigned cycle_count = 0;

  always #1 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Gap / stall lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Beat monitor. Both sides sampled at the edge, so values seen are the ones
  // present at the edge. Result checked before the new item is noted; the
  // block never turns an item around in the same cycle anyway.
  always @(posedge clk) begin
    if (!rst) begin
      if (result.valid && result.ready) sb.check_result(result.best_xor, result.status);
      if (item.valid && item.ready) sb.note_item(item.func, item.value);
    end
  end

  // Result sink: always ready in quiet phases, random holds of either level
  // otherwise, so stalls land on every step of the block's work.
  initial begin : sink_ready
    int hold;
    hold = 0;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!sink_stalls_on) begin
        result.ready <= 1'b1;
      end else begin
        result.ready <= 1'($urandom_range(0, 1));
        hold = pick_gap();
      end
    end
  end

  function automatic logic [VALUE_W-1:0] random_key();
    return VALUE_W'($urandom);
  endfunction

  // A key branching off a known key at some bit: the insert then needs at most
  // bitpos+1 new nodes if the known key is stored, which walks the free count right up to the full edge.
  // Low bit positions dominate so inserts keep landing once the store is tight.
  function automatic logic [VALUE_W-1:0] near_key();
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] below;
    int                 bitpos;
    if (key_pool.size() == 0) return random_key();
    base = key_pool[$urandom_range(0, key_pool.size() - 1)];
    if ($urandom_range(0, 9) == 0) return base;   // duplicate key
    bitpos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, VALUE_W - 1)
                                         : $urandom_range(0, 8);
    below = (VALUE_W'(1) << bitpos) - VALUE_W'(1);
    return base ^ (VALUE_W'(1) << bitpos) ^ (random_key() & below);
  endfunction

  // Query operands: random, near stored keys, stored keys, their complements.
  function automatic logic [VALUE_W-1:0] query_key();
    int                 pick;
    logic [VALUE_W-1:0] base;
    pick = $urandom_range(0, 99);
    if (key_pool.size() == 0 || pick < 40) return random_key();
    if (pick < 70) return near_key();
    base = key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (pick < 85) return base;
    return ~base;
  endfunction

  // One item beat: hold it until accepted, then maybe idle. valid is only
  // lowered when a gap follows, so back-to-back beats keep it high.
  task automatic push_item(input item_func_t f, input logic [VALUE_W-1:0] v);
    int gap;
    item.valid <= 1'b1;
    item.func  <= f;
    item.value <= v;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    if (f == FUNC_INSERT && key_pool.size() < POOL_MAX) key_pool.push_back(v);
    gap = sender_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender holds off until every pending result has come back. The first
  // edge lets the monitor note the last accepted beat.
  task automatic wait_results_done();
    item.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int insert_pct, input int wide_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(1, 100) <= insert_pct) begin
        if ($urandom_range(1, 100) <= wide_pct) push_item(FUNC_INSERT, random_key());
        else push_item(FUNC_INSERT, near_key());
      end else begin
        push_item(FUNC_QUERY, query_key());
      end
    end
  endtask

  initial begin : stimulus
    item.valid <= 1'b0;
    item.func  <= FUNC_INSERT;
    item.value <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: queries on an empty trie, extreme keys, a duplicate key,
    // alternating patterns, keys differing only at the top or bottom bit.
    sender_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    push_item(FUNC_QUERY,  '0);
    push_item(FUNC_QUERY,  '1);
    push_item(FUNC_INSERT, '0);
    push_item(FUNC_INSERT, '0);
    push_item(FUNC_QUERY,  '0);
    push_item(FUNC_QUERY,  '1);
    push_item(FUNC_INSERT, '1);
    push_item(FUNC_QUERY,  '0);
    push_item(FUNC_QUERY,  '1);
    push_item(FUNC_QUERY,  31'h2AAA_AAAA);
    push_item(FUNC_INSERT, 31'h4000_0000);
    push_item(FUNC_INSERT, 31'h0000_0001);
    push_item(FUNC_QUERY,  31'h3FFF_FFFF);
    push_item(FUNC_QUERY,  31'h0000_0001);
    push_item(FUNC_INSERT, 31'h5555_5555);
    push_item(FUNC_INSERT, 31'h2AAA_AAAA);
    push_item(FUNC_QUERY,  31'h5555_5555);
    push_item(FUNC_INSERT, 31'h7FFF_FFFE);
    push_item(FUNC_QUERY,  31'h0000_0001);
    push_item(FUNC_INSERT, '1);
    wait_results_done();

    // Fill: many wide random keys eat ~25 nodes each, so the store runs full
    // in this phase or early in the next; idling on both sides.
    run_phase(250, 60, 60);
    wait_results_done();

    // Full store, no idling at all: mostly prefix-sharing inserts that probe
    // the free-node boundary, queries in between.
    sender_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    run_phase(300, 45, 10);
    wait_results_done();

    // Mixed traffic with heavy idling on both sides.
    sender_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    run_phase(300, 50, 30);
    wait_results_done();

    // Any stray result beat after the last expected one is caught here.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
